// ===== src/fifo_queue_with_delete_by_tag_top_macros.svh =====
// Assertion helpers for the queue datapath.
`ifndef FIFO_QUEUE_WITH_DELETE_BY_TAG_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_BY_TAG_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FQDT_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FQDT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/fqdt_pkg.sv =====
package fqdt_pkg;

   localparam int IN_TAG_BITS    = 32;
   localparam int OUT_TAG_BITS   = 32;
   localparam int FILL_BITS      = 5;
   localparam int KIND_BITS      = 2;
   localparam int REQ_TDATA_BITS = 32;
   localparam int RSP_TDATA_BITS = 40;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - OUT_TAG_BITS - FILL_BITS;

   typedef enum logic [KIND_BITS-1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_DELETE  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DEQ,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // capture the request, clear the scan position
      logic enq_write;    // write the tag at the tail, count up
      logic rd_en;        // read the slot at the scan position
      logic rd_next;      // read one slot past the scan position instead
      logic deq_take;     // take the head tag, advance the head, count down
      logic pos_inc;      // step the scan position
      logic shift_write;  // write read data one slot toward the head, step position
      logic del_done;     // drop the tail slot after a delete, count down
      logic load_rsp;     // load the response register
      logic rsp_err;      // error status for the response being loaded
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      req_kind_type kind;
      logic         tag_zero;
      logic         full;
      logic         empty;
      logic         hit;       // read data equals the request tag
      logic         last;      // scan position is the last stored entry
      logic         rsp_free;  // response register can take a new transaction
   } dp_status_type;

endpackage

// ===== src/fqdt_ram.sv =====
module fqdt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fqdt_dpath.sv =====
`include "fifo_queue_with_delete_by_tag_top_macros.svh"

module fqdt_dpath
   import fqdt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [IN_TAG_BITS-1:0]    req_tag,
   input  req_kind_type              req_kind,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic [0:0]                rsp_tuser
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

   // Slot of the entry that sits offs places behind the head.
   function automatic logic [PTR_W-1:0] to_phys(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return PTR_W'(sum);
   endfunction

   req_kind_type             kind_ff, kind_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [OUT_TAG_BITS-1:0]  res_tag_ff, res_tag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_err_ff, rsp_err_in;
   logic [OUT_TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [FILL_BITS-1:0]     rsp_fill_ff, rsp_fill_in;

   logic [CNT_W-1:0]         pos_next;
   logic [CNT_W-1:0]         rd_logical;
   logic [CNT_W-1:0]         wr_logical;
   logic                     ram_wr_en;
   logic [PTR_W-1:0]         ram_wr_addr;
   logic [TAG_BITS-1:0]      ram_wr_data;
   logic [PTR_W-1:0]         ram_rd_addr;
   logic [TAG_BITS-1:0]      ram_rd_data;
   logic                     rsp_free;

   assign pos_next    = pos_ff + CNT_W'(1);
   assign rd_logical  = cmd.rd_next ? pos_next : pos_ff;
   assign wr_logical  = cmd.enq_write ? count_ff : pos_ff;
   assign ram_rd_addr = to_phys(head_ff, rd_logical);
   assign ram_wr_addr = to_phys(head_ff, wr_logical);
   assign ram_wr_en   = cmd.enq_write | cmd.shift_write;
   assign ram_wr_data = cmd.enq_write ? tag_ff : ram_rd_data;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   fqdt_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      kind_in      = kind_ff;
      tag_in       = tag_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      res_tag_in   = res_tag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_fill_in  = rsp_fill_ff;

      if (cmd.accept) begin
         kind_in    = req_kind;
         tag_in     = TAG_BITS'(req_tag);
         pos_in     = '0;
         res_tag_in = '0;
      end else if (cmd.pos_inc || cmd.shift_write) begin
         pos_in = pos_next;
      end

      if (cmd.enq_write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.deq_take || cmd.del_done) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.deq_take) begin
         res_tag_in = OUT_TAG_BITS'(ram_rd_data);
         head_in    = to_phys(head_ff, CNT_W'(1));
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = cmd.rsp_err;
         rsp_tag_in   = cmd.rsp_err ? '0 : res_tag_ff;
         rsp_fill_in  = FILL_BITS'(count_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      tag_ff      <= tag_in;
      pos_ff      <= pos_in;
      res_tag_ff  <= res_tag_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   always_comb begin
      status.kind     = kind_ff;
      status.tag_zero = (tag_ff == '0);
      status.full     = (count_ff == DEPTH_CNT);
      status.empty    = (count_ff == '0);
      status.hit      = (ram_rd_data == tag_ff);
      status.last     = (pos_next == count_ff);
      status.rsp_free = rsp_free;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{RSP_PAD_BITS{1'b0}}, rsp_fill_ff, rsp_tag_ff};
   assign rsp_tuser[0] = rsp_err_ff;

   `FQDT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT, "count above depth")
   `FQDT_ASSERT_NOW(a_read_stored, clock, reset, cmd.rd_en, rd_logical < count_ff, "read of an empty slot")
   `FQDT_ASSERT_NOW(a_load_free, clock, reset, cmd.load_rsp, rsp_free, "response overwritten")
   `FQDT_ASSERT_NEXT(a_enq_count, clock, reset, cmd.enq_write, count_ff == $past(count_ff) + CNT_W'(1), "enqueue lost count")

endmodule

// ===== src/fqdt_ctrl.sv =====
module fqdt_ctrl
   import fqdt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      err_in     = err_ff;
      cmd        = '0;
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_FINISH;
            err_in   = 1'b1;
            case (status.kind)
               REQ_ENQUEUE: begin
                  if (!status.tag_zero && !status.full) begin
                     cmd.enq_write = 1'b1;
                     err_in        = 1'b0;
                  end
               end
               REQ_DEQUEUE: begin
                  if (!status.empty) begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_DEQ;
                  end
               end
               REQ_DELETE: begin
                  if (!status.tag_zero && !status.empty) begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_SCAN_CMP;
                  end
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end
         ST_DEQ: begin
            cmd.deq_take = 1'b1;
            err_in       = 1'b0;
            state_in     = ST_FINISH;
         end
         ST_SCAN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (status.hit) begin
               state_in = ST_SHIFT_RD;
            end else if (status.last) begin
               err_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.pos_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (status.last) begin
               cmd.del_done = 1'b1;
               err_in       = 1'b0;
               state_in     = ST_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
            state_in        = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_err  = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/fifo_queue_with_delete_by_tag_top.sv =====
// A new request transaction is taken in the cycle after the previous response is loaded.
// Delete time is set by the controller's walk over the tag memory: one read per compare,
// then a read and a write in turn per slot moved toward the head. Reset (synchronous,
// active high) empties the queue; the tag memory itself is not cleared.
module fifo_queue_with_delete_by_tag_top
   import fqdt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // [31:0] item_tag
   input  logic [KIND_BITS-1:0]      req_tuser,  // [1:0] req_type
   // Response channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // [31:0] out_tag, [36:32] fill_count, rest zero
   output logic [0:0]                rsp_tuser   // [0] status
);

   // The queue is held as a circular buffer in a single RAM: a head pointer and a count
   // locate the live entries. Enqueue writes behind the last entry and dequeue just moves
   // the head, so neither has to walk the entries. Delete walks the entries from the
   // head, one compare per read, and on a match copies every younger entry one slot toward
   // the head before dropping the tail. Duplicate tags are allowed; only the oldest match
   // is removed.

   // The request kind arrives on tuser. Code 3 has no meaning and is answered with an error.
   req_kind_type  req_kind;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign req_kind = req_kind_type'(req_tuser);

   // The controller sequences each request; it accepts a transaction only when idle.
   fqdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns the tag memory, pointers and the response register. The response
   // register lets a finished result wait on rsp_tready while the next request is taken.
   fqdt_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tag    (req_tdata[IN_TAG_BITS-1:0]),
      .req_kind   (req_kind),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== test/testbench.sv =====
module testbench;
   import fqdt_pkg::*;

   // The block is built with its default sizes.
   localparam int DEPTH        = 16;
   localparam int TAGW         = 32;
   localparam int ITEMS_PHASE  = 330;
   // This covers a delete that walks the whole queue, the longest request
   // the block can still be working on.
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
   // The one request code that has no meaning.
   localparam logic [KIND_BITS-1:0] REQ_UNUSED = 2'd3;

   // One expected response transaction, with the fields as the block reports them.
   typedef struct packed {
      logic                    status;
      logic [OUT_TAG_BITS-1:0] out_tag;
      logic [FILL_BITS-1:0]    fill_count;
   } queue_rsp_type;

   // The scoreboard keeps its own copy of the tag queue, head first, and the
   // responses that the accepted requests are due to return, oldest first.
   class tag_queue_scoreboard;
      logic [TAGW-1:0] stored_tags[$];
      queue_rsp_type   due_rsps[$];
      int              mismatches;

      task report_mismatch(string what);
         $display("ERROR at %0t: %s", $time, what);
         mismatches++;
      endtask

      function int pending();
         return due_rsps.size();
      endfunction

      // Applies one accepted request to the tag queue and notes the response.
      function void note_request(logic [KIND_BITS-1:0] kind, logic [TAGW-1:0] tag);
         queue_rsp_type rsp;
         int            hit;
         rsp.status  = 1'b1;
         rsp.out_tag = '0;
         hit         = -1;
         case (kind)
            REQ_ENQUEUE: begin
               if (tag != 0 && stored_tags.size() < DEPTH) begin
                  stored_tags.push_back(tag);
                  rsp.status = 1'b0;
               end
            end
            REQ_DEQUEUE: begin
               if (stored_tags.size() > 0) begin
                  rsp.out_tag = stored_tags.pop_front();
                  rsp.status  = 1'b0;
               end
            end
            REQ_DELETE: begin
               // Only the copy nearest the head goes; the rest close up behind it.
               if (tag != 0) begin
                  for (int i = 0; i < stored_tags.size(); i++) begin
                     if (hit < 0 && stored_tags[i] == tag) begin
                        hit = i;
                     end
                  end
                  if (hit >= 0) begin
                     stored_tags.delete(hit);
                     rsp.status = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
         rsp.fill_count = FILL_BITS'(stored_tags.size());
         due_rsps.push_back(rsp);
      endfunction

      task check_response(logic status, logic [OUT_TAG_BITS-1:0] out_tag,
                          logic [FILL_BITS-1:0] fill_count);
         queue_rsp_type want;
         if (due_rsps.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
            return;
         end
         want = due_rsps.pop_front();
         if (status !== want.status) begin
            report_mismatch($sformatf("status %b, expected %b", status, want.status));
         end
         if (out_tag !== want.out_tag) begin
            report_mismatch($sformatf("out_tag %h, expected %h", out_tag, want.out_tag));
         end
         if (fill_count !== want.fill_count) begin
            report_mismatch($sformatf("fill_count %0d, expected %0d",
                                      fill_count, want.fill_count));
         end
      endtask
   endclass

   // Every input of the block holds a known value from time zero on.
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;   // [31:0] item_tag
   logic [KIND_BITS-1:0]      req_tuser  = '0;   // [1:0] req_type
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;         // [31:0] out_tag, [36:32] fill_count
   logic [0:0]                rsp_tuser;         // [0] status

   tag_queue_scoreboard sb = new();

   int sender_idle_pct = 32;
   int receiver_idle_pct = 65;
   int accepted_reqs = 0;

   fifo_queue_with_delete_by_tag_top #(
      .QUEUE_DEPTH(DEPTH),
      .TAG_BITS   (TAGW)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides each cycle whether to stall, at the falling edge before the
   // rising edge that samples it.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= receiver_idle_pct);
   end

   // Both channels are watched at the rising edge. Inputs only move at the falling
   // edge, and the block's outputs still hold their pre-edge values here.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser, req_tdata[TAGW-1:0]);
            accepted_reqs++;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tuser[0], rsp_tdata[OUT_TAG_BITS-1:0],
                              rsp_tdata[OUT_TAG_BITS +: FILL_BITS]);
         end
      end
   end

   // Offers one request transaction, possibly after some idle cycles, and returns
   // at the falling edge after it was taken. The valid stays high on return so a
   // following request can go out back to back.
   task automatic send_request(input logic [KIND_BITS-1:0] kind, input logic [TAGW-1:0] tag);
      int seen;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      seen       = accepted_reqs;
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = tag;
      do @(negedge clock); while (accepted_reqs == seen);
   endtask

   // Holds the request channel quiet until every outstanding response is back.
   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   // Mostly well-formed traffic: enqueues and dequeues in a ratio that drifts so
   // the queue swings between empty and full, and deletes that usually name a
   // stored tag. Tags often come from a small pool so that duplicates build up.
   // The rest is noise: the unused request code, zero tags and random kinds.
   task automatic random_request(input int enq_pct);
      logic [KIND_BITS-1:0] kind;
      logic [TAGW-1:0]      tag;
      int                   size;
      size = sb.stored_tags.size();
      if ($urandom_range(99) < 8) begin
         kind = KIND_BITS'($urandom_range(3));
         tag  = $urandom_range(1) ? '0 : TAGW'($urandom);
      end else if ($urandom_range(99) < enq_pct) begin
         kind = REQ_ENQUEUE;
         tag  = ($urandom_range(3) == 0) ? TAGW'($urandom) : TAGW'($urandom_range(12, 1));
      end else if ($urandom_range(1) == 0) begin
         kind = REQ_DEQUEUE;
         tag  = $urandom;
      end else begin
         kind = REQ_DELETE;
         if (size > 0 && $urandom_range(3) != 0) begin
            tag = sb.stored_tags[$urandom_range(size - 1)];
         end else begin
            tag = $urandom_range(12, 1);
         end
      end
      send_request(kind, tag);
   endtask

   // Main sequence: reset, a directed pass over the corner cases, then three
   // random phases with different idle patterns on the two channels.
   initial begin
      int enq_pct;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Errors on an empty queue, the unused request code and a zero tag.
      send_request(REQ_DEQUEUE, 32'h0000_0000);
      send_request(REQ_DELETE, 32'h0000_0005);
      send_request(REQ_UNUSED, 32'h0000_0007);
      send_request(REQ_ENQUEUE, 32'h0000_0000);
      // Fill the queue with extreme tags and a duplicate, then overfill it.
      send_request(REQ_ENQUEUE, 32'hFFFF_FFFF);
      send_request(REQ_ENQUEUE, 32'h0000_0001);
      send_request(REQ_ENQUEUE, 32'h8000_0000);
      send_request(REQ_ENQUEUE, 32'h0000_0001);
      for (int i = 4; i < DEPTH; i++) begin
         send_request(REQ_ENQUEUE, 32'h1000_0000 + i);
      end
      send_request(REQ_ENQUEUE, 32'h0000_0005);
      // Zero tag and a missing tag on delete, then the first of the duplicates,
      // the tail entry, and the head through a dequeue.
      send_request(REQ_DELETE, 32'h0000_0000);
      send_request(REQ_DELETE, 32'hDEAD_BEEF);
      send_request(REQ_DELETE, 32'h0000_0001);
      send_request(REQ_DELETE, 32'h1000_0000 + DEPTH - 1);
      send_request(REQ_DEQUEUE, 32'h5A5A_5A5A);

      enq_pct = 50;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 32;
               receiver_idle_pct = 65;
            end
            1: begin
               sender_idle_pct   = 65;
               receiver_idle_pct = 32;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         // Each phase opens with an empty pipeline; now and then a pause
         // mid-phase lets the block run dry as well.
         drain_responses();
         for (int i = 0; i < ITEMS_PHASE; i++) begin
            if (i % 40 == 0) begin
               case ($urandom_range(2))
                  0:       enq_pct = 15;
                  1:       enq_pct = 50;
                  default: enq_pct = 85;
               endcase
            end
            if ($urandom_range(49) == 0) begin
               drain_responses();
            end
            random_request(enq_pct);
         end
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("fifo_queue_with_delete_by_tag_top: match");
      end else begin
         $display("fifo_queue_with_delete_by_tag_top: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, so only a hang ends up here.
   initial begin
      #5_000_000;
      $display("fifo_queue_with_delete_by_tag_top: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/fqdt_pkg.sv
src/fqdt_ram.sv
src/fqdt_dpath.sv
src/fqdt_ctrl.sv
src/fifo_queue_with_delete_by_tag_top.sv
test/testbench.sv
